// File: src/aba_pkg.sv
// ----------------------------------------------------------------------------
// aba_pkg
// Shared constants, codes and types of the atlas block allocator.
// ----------------------------------------------------------------------------
package aba_pkg;

	localparam int MaxAtlases = 8;
	localparam int MaxBlocks  = 1024;
	localparam int MaxImages  = 1024;

	localparam int AtlW  = $clog2(MaxAtlases);      // atlas index
	localparam int AcntW = $clog2(MaxAtlases + 1);  // atlas count
	localparam int BlkW  = $clog2(MaxBlocks);       // block number
	localparam int BcntW = $clog2(MaxBlocks + 1);   // block count
	localparam int ImgW  = $clog2(MaxImages);       // image slot
	localparam int IcntW = $clog2(MaxImages + 1);   // image count
	localparam int RefW  = 16;
	localparam int DimW  = 13;
	localparam int FifoAw = AtlW + BlkW;
	localparam int OwnW  = AtlW + BlkW;
	localparam int ImgRamW = RefW + OwnW;

	localparam logic [2:0] ModeAdd    = 3'd0;
	localparam logic [2:0] ModeRemove = 3'd1;
	localparam logic [2:0] ModeAddRef = 3'd2;
	localparam logic [2:0] ModeCreate = 3'd3;
	localparam logic [2:0] ModeQuery  = 3'd4;

	localparam logic [1:0] StOk      = 2'd0;
	localparam logic [1:0] StNoRoom  = 2'd1;
	localparam logic [1:0] StBadId   = 2'd2;
	localparam logic [1:0] StFreed   = 2'd3;

	localparam logic [2:0] RegAtlasW  = 3'd0;
	localparam logic [2:0] RegAtlasH  = 3'd1;
	localparam logic [2:0] RegBlockW  = 3'd2;
	localparam logic [2:0] RegBlockH  = 3'd3;
	localparam logic [2:0] RegCreate  = 3'd4;

	localparam logic [12:0] DefAtlasSize = 13'd512;
	localparam logic [12:0] DefBlockSize = 13'd16;

	// request to the shared divider
	typedef struct packed {
		logic            start;
		logic [DimW-1:0] num;
		logic [DimW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DimW-1:0] quo;
	} div_rsp_t;

endpackage

// File: src/aba_ram.sv
// ----------------------------------------------------------------------------
// aba_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module aba_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// write or read one word a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// File: src/aba_div.sv
// ----------------------------------------------------------------------------
// aba_div
// Restoring divider, one quotient bit a cycle, shared by create.
// ----------------------------------------------------------------------------
module aba_div (
	input  logic              clk,
	input  logic              arst_n,
	input  aba_pkg::div_req_t req,
	output aba_pkg::div_rsp_t rsp
);
	localparam int W = aba_pkg::DimW;
	localparam int CntW = $clog2(W + 1);

	logic [W-1:0]    rem_q, quo_q, den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q, done_q;
	logic [W:0]      trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	// shift in one dividend bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(W);
				rem_q  <= '0;
				quo_q  <= req.num;
				den_q  <= req.den;
			end else if (busy_q) begin
				if (!trial[W]) begin
					rem_q <= trial[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[W-2:0], quo_q[W-1]};
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// File: src/atlas_block_allocator_top.sv
// ----------------------------------------------------------------------------
// atlas_block_allocator_top
// Fixed-block allocator for texture atlases with per-atlas free FIFOs.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, mode..image_id         | beat into block
//  out     | out_valid/out_ready, status..free_blocks  | beat out of block
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | register write
//
// One item at a time. Add walks the image slots (one RAM read each), checks
// the preferred atlas, then scans atlases one a cycle; create adds a check,
// two divisions, a multiply and a write; a FIFO pop adds a read and a wait
// state. Remove and add reference pass image read, wait and update states;
// query, bad ids and unused modes go straight to the result. Reset clears
// counts and pointers; no clearing pass. in_ready is low from accept until
// the result beat is taken by out_ready.
module atlas_block_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [11:0] image_width,
	input  logic [11:0] image_height,
	input  logic [3:0]  pixel_format,
	input  logic [3:0]  atlas_select,
	input  logic [10:0] image_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [10:0] result_image,
	output logic [3:0]  result_atlas,
	output logic [9:0]  block_number,
	output logic        block_freed,
	output logic [10:0] free_blocks,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	localparam int NA = aba_pkg::MaxAtlases;
	localparam int AW = aba_pkg::AtlW;
	localparam int ACW = aba_pkg::AcntW;
	localparam int BW = aba_pkg::BlkW;
	localparam int BCW = aba_pkg::BcntW;
	localparam int IW = aba_pkg::ImgW;
	localparam int ICW = aba_pkg::IcntW;
	localparam int RW = aba_pkg::RefW;
	localparam int DW = aba_pkg::DimW;
	localparam int OW = aba_pkg::OwnW;
	localparam int IRW = aba_pkg::ImgRamW;
	localparam int FAW = aba_pkg::FifoAw;

	typedef enum logic [4:0] {
		S_IDLE, S_SLOT_RD, S_SLOT_CHK, S_PREF, S_SCAN, S_CRT_CHK, S_CRT_DIV1,
		S_CRT_DIV2, S_CRT_MUL, S_CRT_WR, S_ALLOC, S_POP_RD, S_POP_WAIT, S_IMG_RD,
		S_IMG_WAIT, S_IMG_UPD, S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [DW-1:0] cfg_aw_q, cfg_ah_q, cfg_bw_q, cfg_bh_q;
	logic          cfg_cof_q;

	// per-atlas registers
	logic [3:0]     fmt_q   [NA];
	logic [DW-1:0]  gbw_q   [NA];
	logic [DW-1:0]  gbh_q   [NA];
	logic [BCW-1:0] total_q [NA];
	logic [BCW-1:0] left_q  [NA];
	logic [BW-1:0]  head_q  [NA];
	logic [BCW-1:0] fill_q  [NA];
	logic [ACW-1:0] acnt_q;
	logic [ICW-1:0] icnt_q;

	// latched request
	logic [2:0]  mode_q;
	logic [11:0] iw_q, ih_q;
	logic [3:0]  fmt_in_q, sel_q;
	logic [10:0] id_q;
	logic        created_q;

	logic [ICW-1:0] slot_q;
	logic [ACW-1:0] scan_q;
	logic [AW-1:0]  a_q;
	logic [DW-1:0]  qw_q;
	logic [25:0]    prod_q;

	// result registers
	logic [1:0]  st_q;
	logic [10:0] rimg_q, nfree_q;
	logic [3:0]  ratl_q;
	logic [9:0]  rblk_q;
	logic        freed_q;

	// image RAM
	logic           img_we;
	logic [IW-1:0]  img_addr;
	logic [IRW-1:0] img_wdata, img_rdata;
	logic [RW-1:0]  rd_ref;
	logic [AW-1:0]  rd_own;
	logic [BW-1:0]  rd_blk;
	assign rd_ref = img_rdata[IRW-1 -: RW];
	assign rd_own = img_rdata[OW-1 -: AW];
	assign rd_blk = img_rdata[BW-1:0];

	// free FIFO RAM
	logic           ff_we;
	logic [FAW-1:0] ff_addr;
	logic [BW-1:0]  ff_wdata, ff_rdata;

	aba_ram #(.Width(IRW), .Depth(aba_pkg::MaxImages)) u_img_ram (
		.clk(clk), .we(img_we), .addr(img_addr), .wdata(img_wdata), .rdata(img_rdata)
	);
	aba_ram #(.Width(BW), .Depth(NA * aba_pkg::MaxBlocks)) u_fifo_ram (
		.clk(clk), .we(ff_we), .addr(ff_addr), .wdata(ff_wdata), .rdata(ff_rdata)
	);

	aba_pkg::div_req_t div_req;
	aba_pkg::div_rsp_t div_rsp;
	aba_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// fit test for the atlas under test
	logic [AW-1:0] fit_idx;
	logic          fit_in_range, fit_ok;
	logic [3:0]    sel_m1;
	assign sel_m1 = sel_q - 4'd1;
	always_comb begin
		fit_idx = scan_q[AW-1:0];
		fit_in_range = scan_q < acnt_q;
		if (state_q == S_PREF) begin
			fit_idx = sel_m1[AW-1:0];
			fit_in_range = (sel_q != 4'd0) && ({1'b0, sel_m1} < 5'(acnt_q));
		end
		fit_ok = fit_in_range && (fmt_q[fit_idx] == fmt_in_q)
			&& ((left_q[fit_idx] + fill_q[fit_idx]) != '0)
			&& ({1'b0, iw_q} + 13'd2 <= gbw_q[fit_idx])
			&& ({1'b0, ih_q} + 13'd2 <= gbh_q[fit_idx]);
	end

	logic create_ok;
	assign create_ok = (acnt_q < ACW'(NA)) && (cfg_bw_q != '0) && (cfg_bh_q != '0)
		&& (cfg_bw_q <= cfg_aw_q) && (cfg_bh_q <= cfg_ah_q);

	logic [IW-1:0]  id_idx;
	logic [10:0]    id_m1;
	logic [BW:0]    push_pos;
	logic [BCW-1:0] tot_sat;
	assign id_m1   = id_q - 11'd1;
	assign id_idx  = id_m1[IW-1:0];
	assign push_pos = {1'b0, head_q[rd_own]} + fill_q[rd_own][BW:0];
	assign tot_sat = (prod_q > 26'(aba_pkg::MaxBlocks)) ? BCW'(aba_pkg::MaxBlocks)
		: prod_q[BCW-1:0];

	logic [BW:0] wrap_pos;
	assign wrap_pos = (push_pos >= (BW+1)'(aba_pkg::MaxBlocks))
		? push_pos - (BW+1)'(aba_pkg::MaxBlocks) : push_pos;

	// memory ports and divider request
	always_comb begin
		img_we = 1'b0;
		img_addr = slot_q[IW-1:0];
		img_wdata = '0;
		ff_we = 1'b0;
		ff_addr = {a_q, head_q[a_q]};
		ff_wdata = rd_blk;
		div_req = '0;
		case (state_q)
			S_IMG_RD: img_addr = id_idx;
			S_IMG_WAIT: begin
				// add records the new slot: one reference, owner and block
				if (mode_q == aba_pkg::ModeAdd) begin
					img_we = 1'b1;
					img_wdata = {RW'(1), a_q, rblk_q};
				end else begin
					img_addr = id_idx;
				end
			end
			S_IMG_UPD: begin
				img_addr = id_idx;
				if (rd_ref != '0) begin
					if (mode_q == aba_pkg::ModeAddRef) begin
						img_we = 1'b1;
						img_wdata = {(rd_ref == '1) ? rd_ref : rd_ref + 1'b1, rd_own, rd_blk};
					end else begin
						img_we = 1'b1;
						img_wdata = {(rd_ref - 1'b1 < RW'(2)) ? RW'(0) : rd_ref - 1'b1,
							rd_own, rd_blk};
						if ((rd_ref - 1'b1 < RW'(2)) && (fill_q[rd_own] < BCW'(aba_pkg::MaxBlocks))) begin
							ff_we = 1'b1;
							ff_addr = {rd_own, wrap_pos[BW-1:0]};
						end
					end
				end
			end
			S_CRT_CHK: begin
				div_req.start = create_ok;
				div_req.num = cfg_aw_q;
				div_req.den = cfg_bw_q;
			end
			S_CRT_DIV1: begin
				div_req.start = div_rsp.done;
				div_req.num = cfg_ah_q;
				div_req.den = cfg_bh_q;
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign cfg_ready = (state_q == S_IDLE);
	assign status = st_q;
	assign result_image = rimg_q;
	assign result_atlas = ratl_q;
	assign block_number = rblk_q;
	assign block_freed = freed_q;
	assign free_blocks = nfree_q;

	logic [BCW-1:0] alloc_blk;
	assign alloc_blk = total_q[a_q] - left_q[a_q];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cfg_aw_q  <= aba_pkg::DefAtlasSize;
			cfg_ah_q  <= aba_pkg::DefAtlasSize;
			cfg_bw_q  <= aba_pkg::DefBlockSize;
			cfg_bh_q  <= aba_pkg::DefBlockSize;
			cfg_cof_q <= 1'b1;
			acnt_q    <= '0;
			icnt_q    <= '0;
			for (int i = 0; i < NA; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							aba_pkg::RegAtlasW: cfg_aw_q <= cfg_data;
							aba_pkg::RegAtlasH: cfg_ah_q <= cfg_data;
							aba_pkg::RegBlockW: cfg_bw_q <= cfg_data;
							aba_pkg::RegBlockH: cfg_bh_q <= cfg_data;
							aba_pkg::RegCreate: cfg_cof_q <= cfg_data[0];
							default: ;
						endcase
					end
					if (in_valid) begin
						mode_q <= mode; iw_q <= image_width; ih_q <= image_height;
						fmt_in_q <= pixel_format; sel_q <= atlas_select; id_q <= image_id;
						st_q <= aba_pkg::StOk; rimg_q <= '0; ratl_q <= '0;
						rblk_q <= '0; freed_q <= 1'b0; nfree_q <= '0;
						slot_q <= '0; scan_q <= '0; created_q <= 1'b0;
						case (mode)
							aba_pkg::ModeAdd: state_q <= S_SLOT_RD;
							aba_pkg::ModeRemove, aba_pkg::ModeAddRef: begin
								if (image_id == '0 || image_id > 11'(icnt_q)) begin
									st_q <= aba_pkg::StBadId;
									state_q <= S_DONE;
								end else begin
									state_q <= S_IMG_RD;
								end
							end
							aba_pkg::ModeCreate: state_q <= S_CRT_CHK;
							aba_pkg::ModeQuery: begin
								if (atlas_select == '0 || 5'(atlas_select) > 5'(acnt_q)) begin
									st_q <= aba_pkg::StBadId;
								end else begin
									ratl_q <= atlas_select;
									nfree_q <= 11'(left_q[AW'(atlas_select - 4'd1)]
										+ fill_q[AW'(atlas_select - 4'd1)]);
								end
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				// walk slots for a zero refcount (read issued for slot_q)
				S_SLOT_RD: begin
					if (slot_q == icnt_q) begin
						state_q <= (icnt_q >= ICW'(aba_pkg::MaxImages)) ? S_DONE : S_PREF;
						if (icnt_q >= ICW'(aba_pkg::MaxImages)) st_q <= aba_pkg::StNoRoom;
					end else begin
						state_q <= S_SLOT_CHK;
					end
				end
				S_SLOT_CHK: begin
					if (rd_ref == '0) begin
						state_q <= S_PREF;
					end else begin
						slot_q <= slot_q + 1'b1;
						state_q <= S_SLOT_RD;
					end
				end
				S_PREF: begin
					if (fit_ok) begin
						a_q <= sel_m1[AW-1:0];
						state_q <= S_ALLOC;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (created_q) begin
						if (fit_ok) begin
							a_q <= scan_q[AW-1:0];
							state_q <= S_ALLOC;
						end else begin
							st_q <= aba_pkg::StNoRoom;
							state_q <= S_DONE;
						end
					end else if (scan_q >= acnt_q) begin
						if (cfg_cof_q) begin
							state_q <= S_CRT_CHK;
						end else begin
							st_q <= aba_pkg::StNoRoom;
							state_q <= S_DONE;
						end
					end else if (fit_ok) begin
						a_q <= scan_q[AW-1:0];
						state_q <= S_ALLOC;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_CRT_CHK: begin
					if (create_ok) begin
						state_q <= S_CRT_DIV1;
					end else begin
						st_q <= aba_pkg::StNoRoom;
						state_q <= S_DONE;
					end
				end
				S_CRT_DIV1: begin
					if (div_rsp.done) begin
						qw_q <= div_rsp.quo;
						state_q <= S_CRT_DIV2;
					end
				end
				S_CRT_DIV2: begin
					if (div_rsp.done) begin
						prod_q <= qw_q * div_rsp.quo;
						state_q <= S_CRT_MUL;
					end
				end
				S_CRT_MUL: state_q <= S_CRT_WR;
				S_CRT_WR: begin
					fmt_q[acnt_q[AW-1:0]]   <= fmt_in_q;
					gbw_q[acnt_q[AW-1:0]]   <= cfg_bw_q;
					gbh_q[acnt_q[AW-1:0]]   <= cfg_bh_q;
					total_q[acnt_q[AW-1:0]] <= tot_sat;
					left_q[acnt_q[AW-1:0]]  <= tot_sat - 1'b1;
					head_q[acnt_q[AW-1:0]]  <= '0;
					fill_q[acnt_q[AW-1:0]]  <= '0;
					acnt_q <= acnt_q + 1'b1;
					if (mode_q == aba_pkg::ModeCreate) begin
						ratl_q <= 4'(acnt_q + 1'b1);
						state_q <= S_DONE;
					end else begin
						scan_q <= acnt_q;
						created_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_ALLOC: begin
					rimg_q <= 11'(slot_q + 1'b1);
					ratl_q <= 4'(a_q) + 4'd1;
					if (left_q[a_q] != '0) begin
						rblk_q <= alloc_blk[BW-1:0];
						left_q[a_q] <= left_q[a_q] - 1'b1;
						state_q <= S_IMG_WAIT;
					end else begin
						state_q <= S_POP_RD;
					end
				end
				S_POP_RD: state_q <= S_POP_WAIT;
				S_POP_WAIT: begin
					rblk_q <= ff_rdata;
					head_q[a_q] <= (head_q[a_q] == BW'(aba_pkg::MaxBlocks - 1)) ? '0
						: head_q[a_q] + 1'b1;
					fill_q[a_q] <= fill_q[a_q] - 1'b1;
					state_q <= S_IMG_WAIT;
				end
				S_IMG_RD: state_q <= S_IMG_WAIT;
				S_IMG_WAIT: begin
					if (mode_q == aba_pkg::ModeAdd) begin
						if (slot_q == icnt_q) icnt_q <= icnt_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_IMG_UPD;
					end
				end
				S_IMG_UPD: begin
					ratl_q <= 4'(rd_own) + 4'd1;
					if (rd_ref == '0) begin
						st_q <= aba_pkg::StFreed;
					end else if (mode_q == aba_pkg::ModeRemove && (rd_ref - 1'b1 < RW'(2))) begin
						freed_q <= 1'b1;
						if (fill_q[rd_own] < BCW'(aba_pkg::MaxBlocks)) begin
							fill_q[rd_own] <= fill_q[rd_own] + 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result changed while stalled");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("ready while result pending");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		acnt_q <= ACW'(NA))
		else $error("atlas count overflow");
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the atlas block allocator: a directed table, then
// four random phases under different atlas geometries, each result beat held
// to a typed result or a bench model of atlases, free FIFOs and image slots.
// ----------------------------------------------------------------------------
module tb_top;

	// modes the block does not decode
	localparam logic [2:0] ModeSpare5 = 3'd5;
	localparam logic [2:0] ModeSpare6 = 3'd6;
	localparam logic [2:0] ModeSpare7 = 3'd7;
	localparam int PhaseItems = 130;

	typedef struct packed {
		logic [2:0]  mode;
		logic [11:0] iw;
		logic [11:0] ih;
		logic [3:0]  fmt;
		logic [3:0]  sel;
		logic [10:0] id;
	} alloc_req_t;

	localparam int ReqBits = $bits(alloc_req_t);

	typedef struct packed {
		logic [1:0]  status;
		logic [10:0] rimg;
		logic [3:0]  ratl;
		logic [9:0]  rblk;
		logic        freed;
		logic [10:0] nfree;
	} alloc_res_t;

	typedef struct {
		bit         is_reg;
		logic [2:0] ridx;
		logic [12:0] rval;
		alloc_req_t q;
		bit         typed;
		alloc_res_t e;
	} dir_row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic [2:0]  mode, cfg_index;
	logic [11:0] image_width, image_height;
	logic [3:0]  pixel_format, atlas_select, result_atlas;
	logic [10:0] image_id, result_image, free_blocks;
	logic [1:0]  status;
	logic [9:0]  block_number;
	logic        block_freed;
	logic [12:0] cfg_data;

	atlas_block_allocator_top uut (.*);

	// model of the allocator state
	int new_aw, new_ah, new_bw, new_bh, grow_on_fail;
	int n_atlas, n_img;
	int atl_fmt[aba_pkg::MaxAtlases], atl_bw[aba_pkg::MaxAtlases], atl_bh[aba_pkg::MaxAtlases];
	int atl_total[aba_pkg::MaxAtlases], atl_left[aba_pkg::MaxAtlases];
	int fifo_head[aba_pkg::MaxAtlases], fifo_fill[aba_pkg::MaxAtlases];
	int fifo_mem[aba_pkg::MaxAtlases][aba_pkg::MaxBlocks];
	int img_refs[aba_pkg::MaxImages], img_atl[aba_pkg::MaxImages], img_blk[aba_pkg::MaxImages];

	alloc_res_t pending_res[$];
	bit         cur_typed;
	alloc_res_t cur_typed_res;
	int errors, mismatches, n_sent, n_seen, hold_cycles;
	bit quiet;

	function automatic int make_atlas(int fmt);
		int a;
		if (n_atlas >= aba_pkg::MaxAtlases) return 0;
		if (new_bw == 0 || new_bh == 0 || new_bw > new_aw || new_bh > new_ah) return 0;
		a = n_atlas;
		atl_fmt[a] = fmt;
		atl_bw[a] = new_bw;
		atl_bh[a] = new_bh;
		atl_total[a] = (new_aw / new_bw) * (new_ah / new_bh);
		if (atl_total[a] > aba_pkg::MaxBlocks) atl_total[a] = aba_pkg::MaxBlocks;
		atl_left[a] = atl_total[a] - 1;
		fifo_head[a] = 0;
		fifo_fill[a] = 0;
		n_atlas = a + 1;
		return a + 1;
	endfunction

	function automatic bit fits(int a, int w, int h, int fmt);
		if (a >= n_atlas) return 0;
		if (atl_fmt[a] != fmt) return 0;
		if (atl_left[a] + fifo_fill[a] == 0) return 0;
		return (w + 2 <= atl_bw[a]) && (h + 2 <= atl_bh[a]);
	endfunction

	// compute one result and advance the allocator state
	function automatic alloc_res_t allocate_step(alloc_req_t q);
		alloc_res_t r;
		int slot, a, blk, n, s, p;
		bit found;
		r = '0;
		case (q.mode)
			aba_pkg::ModeAdd: begin
				slot = n_img;
				for (int i = 0; i < n_img; i++)
					if (img_refs[i] == 0) begin
						slot = i;
						break;
					end
				if (slot >= aba_pkg::MaxImages) begin
					r.status = aba_pkg::StNoRoom;
				end else begin
					found = 0;
					a = 0;
					if (q.sel != 0 && fits(int'(q.sel) - 1, q.iw, q.ih, q.fmt)) begin
						found = 1;
						a = int'(q.sel) - 1;
					end
					for (int i = 0; !found && i < n_atlas; i++)
						if (fits(i, q.iw, q.ih, q.fmt)) begin
							found = 1;
							a = i;
						end
					if (!found && grow_on_fail != 0) begin
						n = make_atlas(q.fmt);
						if (n != 0 && fits(n - 1, q.iw, q.ih, q.fmt)) begin
							found = 1;
							a = n - 1;
						end
					end
					if (!found) begin
						r.status = aba_pkg::StNoRoom;
					end else begin
						if (atl_left[a] != 0) begin
							blk = atl_total[a] - atl_left[a];
							atl_left[a]--;
						end else begin
							blk = fifo_mem[a][fifo_head[a]];
							fifo_head[a] = (fifo_head[a] + 1) % aba_pkg::MaxBlocks;
							fifo_fill[a]--;
						end
						img_refs[slot] = 1;
						img_atl[slot] = a;
						img_blk[slot] = blk;
						if (slot == n_img) n_img++;
						r.rimg = 11'(slot + 1);
						r.ratl = 4'(a + 1);
						r.rblk = 10'(blk);
					end
				end
			end
			aba_pkg::ModeRemove, aba_pkg::ModeAddRef: begin
				if (q.id == 0 || q.id > n_img) begin
					r.status = aba_pkg::StBadId;
				end else begin
					s = int'(q.id) - 1;
					r.ratl = 4'(img_atl[s] + 1);
					if (img_refs[s] == 0) begin
						r.status = aba_pkg::StFreed;
					end else if (q.mode == aba_pkg::ModeAddRef) begin
						if (img_refs[s] < 16'hFFFF) img_refs[s]++;
					end else begin
						img_refs[s]--;
						if (img_refs[s] < 2) begin
							img_refs[s] = 0;
							// drop the push when the FIFO is full
							if (fifo_fill[img_atl[s]] < aba_pkg::MaxBlocks) begin
								p = (fifo_head[img_atl[s]] + fifo_fill[img_atl[s]])
									% aba_pkg::MaxBlocks;
								fifo_mem[img_atl[s]][p] = img_blk[s];
								fifo_fill[img_atl[s]]++;
							end
							r.freed = 1'b1;
						end
					end
				end
			end
			aba_pkg::ModeCreate: begin
				r.ratl = 4'(make_atlas(q.fmt));
				if (r.ratl == 0) r.status = aba_pkg::StNoRoom;
			end
			aba_pkg::ModeQuery: begin
				if (q.sel == 0 || q.sel > n_atlas) begin
					r.status = aba_pkg::StBadId;
				end else begin
					r.ratl = q.sel;
					r.nfree = 11'(atl_left[q.sel - 1] + fifo_fill[q.sel - 1]);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic alloc_req_t mk_req(logic [2:0] m, int w, int h, int f, int sl, int id);
		alloc_req_t q;
		q.mode = m;
		q.iw = 12'(w);
		q.ih = 12'(h);
		q.fmt = 4'(f);
		q.sel = 4'(sl);
		q.id = 11'(id);
		return q;
	endfunction

	function automatic alloc_res_t mk_res(logic [1:0] st, int im, int at, int bl, int fr, int nf);
		alloc_res_t r;
		r.status = st;
		r.rimg = 11'(im);
		r.ratl = 4'(at);
		r.rblk = 10'(bl);
		r.freed = 1'(fr);
		r.nfree = 11'(nf);
		return r;
	endfunction

	// random item, mostly well-formed against the current image population
	function automatic alloc_req_t rand_req();
		alloc_req_t q;
		int r;
		q.mode = aba_pkg::ModeAdd;
		q.iw = 12'($urandom_range(0, 14));
		q.ih = 12'($urandom_range(0, 14));
		q.fmt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(0, 3));
		q.sel = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(0, 8));
		q.id = (n_img > 0) ? 11'($urandom_range(1, n_img)) : 11'd1;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: q.id = 11'd0;
				1: q.id = 11'(n_img + 1);
				2: q.id = 11'h7FF;
				default: q.id = 11'($urandom_range(0, 2047));
			endcase
		end
		r = $urandom_range(0, 99);
		if (r < 45) begin
			if ($urandom_range(0, 9) == 0) begin
				q.iw = 12'($urandom_range(0, 4095));
				q.ih = 12'($urandom_range(0, 4095));
			end
		end else if (r < 70) q.mode = aba_pkg::ModeRemove;
		else if (r < 82) q.mode = aba_pkg::ModeAddRef;
		else if (r < 87) q.mode = aba_pkg::ModeCreate;
		else if (r < 95) q.mode = aba_pkg::ModeQuery;
		else begin
			q = alloc_req_t'(ReqBits'({$urandom(), $urandom()}));
			q.mode = 3'($urandom_range(ModeSpare5, ModeSpare7));
		end
		return q;
	endfunction

	// clock and reset
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1;
	end

	// receiver: random stalls, quiet stretch, long hold-off on request
	initial begin
		out_ready = 0;
		forever @(negedge clk) begin
			if (hold_cycles > 0) begin
				out_ready = 0;
				hold_cycles--;
			end else if (quiet) out_ready = 1;
			else out_ready = ($urandom_range(0, 99) >= 14);
		end
	end

	// predict on each accepted beat, check each result beat
	always @(posedge clk) begin
		alloc_res_t got, want, pred;
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				aba_pkg::RegAtlasW: new_aw = cfg_data;
				aba_pkg::RegAtlasH: new_ah = cfg_data;
				aba_pkg::RegBlockW: new_bw = cfg_data;
				aba_pkg::RegBlockH: new_bh = cfg_data;
				aba_pkg::RegCreate: grow_on_fail = cfg_data[0];
				default: ;
			endcase
		end
		if (arst_n && in_valid && in_ready) begin
			pred = allocate_step({mode, image_width, image_height, pixel_format,
				atlas_select, image_id});
			pending_res.insert(pending_res.size(), cur_typed ? cur_typed_res : pred);
		end
		if (arst_n && out_valid && out_ready) begin
			n_seen++;
			got = {status, result_image, result_atlas, block_number, block_freed, free_blocks};
			if (pending_res.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %p", got);
			end else begin
				want = pending_res.pop_front();
				if (got.status !== want.status || got.rimg !== want.rimg ||
					got.ratl !== want.ratl || got.rblk !== want.rblk ||
					got.freed !== want.freed || got.nfree !== want.nfree) begin
					mismatches++;
					errors++;
					if (mismatches <= 10)
						$display("mismatch at %0t: expected %p got %p", $realtime, want, got);
				end
			end
		end
	end

	task automatic send(alloc_req_t q, bit typed, alloc_res_t e);
		while (!quiet && $urandom_range(0, 99) < 14) begin
			in_valid = 0;
			@(negedge clk);
		end
		{mode, image_width, image_height, pixel_format, atlas_select, image_id} = q;
		cur_typed = typed;
		cur_typed_res = e;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		n_sent++;
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic wait_drain();
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [12:0] val);
		wait_drain();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_geometry(int aw, int ah, int bw, int bh, int grow);
		write_reg(aba_pkg::RegAtlasW, 13'(aw));
		write_reg(aba_pkg::RegAtlasH, 13'(ah));
		write_reg(aba_pkg::RegBlockW, 13'(bw));
		write_reg(aba_pkg::RegBlockH, 13'(bh));
		write_reg(aba_pkg::RegCreate, 13'(grow));
	endtask

	initial begin
		dir_row_t rows[$];
		alloc_res_t none;
		none = '0;
		new_aw = aba_pkg::DefAtlasSize;
		new_ah = aba_pkg::DefAtlasSize;
		new_bw = aba_pkg::DefBlockSize;
		new_bh = aba_pkg::DefBlockSize;
		grow_on_fail = 1;
		{in_valid, cfg_valid, cfg_index, cfg_data, quiet, hold_cycles} = '0;
		{mode, image_width, image_height, pixel_format, atlas_select, image_id} = '0;
		{n_atlas, n_img, errors, mismatches, n_sent, n_seen} = '0;

		// directed table: typed results where obvious, model otherwise
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeQuery, 0, 0, 0, 1, 0), 1,
			mk_res(aba_pkg::StBadId, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeCreate, 0, 0, 0, 0, 0), 1,
			mk_res(aba_pkg::StOk, 0, 1, 0, 0, 0)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeQuery, 0, 0, 0, 1, 0), 1,
			mk_res(aba_pkg::StOk, 0, 1, 0, 0, 1023)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeAdd, 14, 14, 0, 0, 0), 1,
			mk_res(aba_pkg::StOk, 1, 1, 1, 0, 0)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeAdd, 4095, 4095, 0, 0, 0), 1,
			mk_res(aba_pkg::StNoRoom, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeRemove, 0, 0, 0, 0, 0), 1,
			mk_res(aba_pkg::StBadId, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeRemove, 0, 0, 0, 0, 2047), 1,
			mk_res(aba_pkg::StBadId, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeAddRef, 0, 0, 0, 0, 1), 1,
			mk_res(aba_pkg::StOk, 0, 1, 0, 0, 0)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeRemove, 0, 0, 0, 0, 1), 1,
			mk_res(aba_pkg::StOk, 0, 1, 0, 1, 0)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeAddRef, 0, 0, 0, 0, 1), 1,
			mk_res(aba_pkg::StFreed, 0, 1, 0, 0, 0)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeRemove, 0, 0, 0, 0, 1), 1,
			mk_res(aba_pkg::StFreed, 0, 1, 0, 0, 0)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeAdd, 0, 0, 15, 12, 0), 0, none});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeAdd, 0, 0, 0, 2, 0), 0, none});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeQuery, 0, 0, 0, 0, 0), 1,
			mk_res(aba_pkg::StBadId, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeQuery, 0, 0, 0, 15, 0), 1,
			mk_res(aba_pkg::StBadId, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(ModeSpare5, 4095, 4095, 15, 15, 2047), 1,
			none});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(ModeSpare6, 4095, 0, 15, 0, 2047), 1, none});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(ModeSpare7, 0, 4095, 0, 15, 0), 1, none});
		rows.insert(rows.size(), '{1, aba_pkg::RegBlockW, 13'd4096, '0, 0, none});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeCreate, 0, 0, 1, 0, 0), 1,
			mk_res(aba_pkg::StNoRoom, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{1, aba_pkg::RegBlockW, 13'd16, '0, 0, none});
		rows.insert(rows.size(), '{1, aba_pkg::RegCreate, 13'd0, '0, 0, none});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeAdd, 1, 1, 9, 0, 0), 1,
			mk_res(aba_pkg::StNoRoom, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{1, aba_pkg::RegCreate, 13'd1, '0, 0, none});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeQuery, 0, 0, 0, 3, 0), 0, none});
		rows.insert(rows.size(), '{0, 0, 0, mk_req(aba_pkg::ModeAdd, 13, 13, 15, 3, 0), 0, none});

		wait (arst_n === 1'b1);
		@(negedge clk);
		foreach (rows[i]) begin
			if (rows[i].is_reg) write_reg(rows[i].ridx, rows[i].rval);
			else send(rows[i].q, rows[i].typed, rows[i].e);
		end

		// small atlases that fill and recycle blocks through the FIFO
		set_geometry(64, 64, 16, 16, 1);
		for (int i = 0; i < PhaseItems; i++) begin
			if (i == 20) hold_cycles = 400;
			quiet = (i >= 50 && i < 95);
			send(rand_req(), 0, none);
		end
		quiet = 0;

		// largest geometry, no growth; pause mid-phase until drained
		set_geometry(4096, 4096, 4096, 4096, 0);
		for (int i = 0; i < PhaseItems; i++) begin
			if (i == PhaseItems / 2) wait_drain();
			send(rand_req(), 0, none);
		end

		// smallest geometry: new atlases hold only the reserved block
		set_geometry(1, 1, 1, 1, 1);
		for (int i = 0; i < PhaseItems; i++) send(rand_req(), 0, none);

		set_geometry(512, 256, 8, 32, 1);
		for (int i = 0; i < PhaseItems; i++) send(rand_req(), 0, none);

		wait_drain();
		repeat (200) @(posedge clk);
		errors += pending_res.size();
		$display("covered %0d items, %0d result beats, %0d atlases, %0d image slots",
			n_sent, n_seen, n_atlas, n_img);
		$display("four geometries plus defaults, long output hold-off and a drained pause");
		if (errors == 0) $display("atlas_block_allocator_top regression: pass");
		else $display("atlas_block_allocator_top regression: fail");
		$finish;
	end

	// hard stop
	initial begin
		#20_000_000;
		$display("atlas_block_allocator_top regression: fail");
		$finish;
	end

endmodule
